// File: hdl/kli_pkg.sv
// Shared types, constants and channel helpers for the keyframe light interpolator.
package kli_pkg;

	localparam int TIME_W   = 25;
	localparam int NOW_W    = 24;
	localparam int LVL_W    = 64;
	localparam int NUM_CHAN = 6;
	localparam int CHAN_W   = 3;
	localparam int QUO_W    = 17;
	localparam int PRD_W    = 44;
	localparam int CNT_W    = 5;
	localparam int DIF_W    = 26;

	localparam logic signed [TIME_W-1:0] END_MARK = -25'sd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic load_we;
		logic latch_now;
		logic t_sel_to;
		logic cap_ft;
		logic cap_tt;
		logic advance;
		logic set_done;
		logic led_clr;
		logic led_inc;
		logic l_sel_to;
		logic cap_fl;
		logic cap_tl;
		logic chan_clr;
		logic chan_inc;
		logic mul;
		logic div_start;
		logic div_step;
		logic chan_done;
		logic out_load;
		logic out_ended;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic in_range;
		logic to_at_end;
		logic tt_end;
		logic div_last;
		logic chan_last;
		logic led_last;
		logic out_free;
	} sts_t;

	// channel c of a packed level word: 0..3 bytes, 4..5 halfwords
	function automatic logic [15:0] chan_get(input logic [LVL_W-1:0] w,
			input logic [CHAN_W-1:0] c);
		logic [15:0] r;
		case (c)
			3'd0:    r = {8'd0, w[7:0]};
			3'd1:    r = {8'd0, w[15:8]};
			3'd2:    r = {8'd0, w[23:16]};
			3'd3:    r = {8'd0, w[31:24]};
			3'd4:    r = w[47:32];
			3'd5:    r = w[63:48];
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic [LVL_W-1:0] chan_put(input logic [LVL_W-1:0] w,
			input logic [CHAN_W-1:0] c, input logic [15:0] v);
		logic [LVL_W-1:0] r;
		r = w;
		case (c)
			3'd0:    r[7:0]   = v[7:0];
			3'd1:    r[15:8]  = v[7:0];
			3'd2:    r[23:16] = v[7:0];
			3'd3:    r[31:24] = v[7:0];
			3'd4:    r[47:32] = v;
			3'd5:    r[63:48] = v;
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/kli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/kli_dp.sv
// Datapath: key tables, key pointers, multiplier, serial divider, output register.
module kli_dp #(
	parameter int KEY_COUNT = 256,
	parameter int LED_COUNT = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kli_pkg::cmd_t              cmd,
	output kli_pkg::sts_t              sts,
	input  logic [7:0]                 key_index,
	input  logic signed [24:0]         key_time,
	input  logic [2:0]                 led_index,
	input  logic [kli_pkg::LVL_W-1:0]  load_levels,
	input  logic [kli_pkg::NOW_W-1:0]  now_ms,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [2:0]                 out_led,
	output logic [kli_pkg::LVL_W-1:0]  out_levels,
	output logic                       out_ended,
	output logic                       out_last
);

	localparam int KW  = $clog2(KEY_COUNT);
	localparam int LW  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int LVD = KEY_COUNT * LED_COUNT;
	localparam int LVW = $clog2(LVD);

	logic [KW-1:0]  from_q;
	logic [KW:0]    to_q;
	logic           done_q;
	logic [LW-1:0]  led_q;
	logic [kli_pkg::CHAN_W-1:0] chan_q;
	logic [kli_pkg::CNT_W-1:0]  cnt_q;
	logic           out_valid_q;

	logic [kli_pkg::NOW_W-1:0]          now_q;
	logic signed [kli_pkg::TIME_W-1:0]  ft_q, tt_q;
	logic [kli_pkg::LVL_W-1:0]          fl_q, tl_q, res_q;
	logic signed [kli_pkg::PRD_W-1:0]   prod_s1;
	logic [15:0]                        fv_s1;
	logic [kli_pkg::PRD_W-1:0]          rem_q, dsh_q;
	logic [kli_pkg::QUO_W-1:0]          quo_q;
	logic                               neg_q;
	logic [2:0]                         oled_q;
	logic [kli_pkg::LVL_W-1:0]          olev_q;
	logic                               oend_q, olast_q;

	logic                               load_ok;
	logic [KW-1:0]                      t_raddr;
	logic [kli_pkg::TIME_W-1:0]         t_rdata;
	logic [LVW-1:0]                     l_waddr, l_raddr;
	logic [KW-1:0]                      l_key;
	logic [kli_pkg::LVL_W-1:0]          l_rdata;

	logic signed [kli_pkg::DIF_W:0]     now_s, ft_s, tt_s, dnow, span;
	logic [15:0]                        fv, tv;
	logic signed [16:0]                 diff;
	logic signed [kli_pkg::PRD_W-1:0]   abs_prod;
	logic                               ge;
	logic signed [17:0]                 qs, v;

	assign load_ok = (32'(key_index) < KEY_COUNT) && (32'(led_index) < LED_COUNT);
	assign t_raddr = cmd.t_sel_to ? to_q[KW-1:0] : from_q;
	assign l_waddr = LVW'(KW'(key_index)) * LVW'(LED_COUNT) + LVW'(led_index);
	assign l_key   = cmd.l_sel_to ? to_q[KW-1:0] : from_q;
	assign l_raddr = LVW'(l_key) * LVW'(LED_COUNT) + LVW'(led_q);

	kli_ram #(.WIDTH(kli_pkg::TIME_W), .DEPTH(KEY_COUNT)) u_times (
		.clk   (clk),
		.we    (cmd.load_we && load_ok),
		.waddr (KW'(key_index)),
		.wdata (key_time),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	kli_ram #(.WIDTH(kli_pkg::LVL_W), .DEPTH(LVD)) u_levels (
		.clk   (clk),
		.we    (cmd.load_we && load_ok),
		.waddr (l_waddr),
		.wdata (load_levels),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	assign now_s = signed'({3'd0, now_q});
	assign ft_s  = (kli_pkg::DIF_W+1)'(ft_q);
	assign tt_s  = (kli_pkg::DIF_W+1)'(tt_q);
	assign dnow  = now_s - ft_s;
	assign span  = tt_s - ft_s;
	assign fv    = kli_pkg::chan_get(fl_q, chan_q);
	assign tv    = kli_pkg::chan_get(tl_q, chan_q);
	assign diff  = signed'({1'b0, tv}) - signed'({1'b0, fv});
	assign abs_prod = prod_s1[kli_pkg::PRD_W-1] ? -prod_s1 : prod_s1;
	assign ge    = rem_q >= dsh_q;
	// floor toward minus infinity on a negative numerator with remainder
	assign qs    = neg_q ? (-signed'({1'b0, quo_q}) - 18'(rem_q != '0))
	                     : signed'({1'b0, quo_q});
	assign v     = signed'({2'b0, fv_s1}) + qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			from_q      <= '0;
			to_q        <= '0;
			done_q      <= 1'b0;
			led_q       <= '0;
			chan_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.advance) begin
				from_q <= to_q[KW-1:0];
				to_q   <= to_q + 1'b1;
			end
			if (cmd.set_done) begin
				done_q <= 1'b1;
			end
			if (cmd.led_clr) begin
				led_q <= '0;
			end else if (cmd.led_inc) begin
				led_q <= led_q + 1'b1;
			end
			if (cmd.chan_clr) begin
				chan_q <= '0;
			end else if (cmd.chan_inc) begin
				chan_q <= chan_q + 1'b1;
			end
			if (cmd.div_start) begin
				cnt_q <= kli_pkg::CNT_W'(kli_pkg::QUO_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_now) begin
			now_q <= now_ms;
		end
		if (cmd.cap_ft) begin
			ft_q <= t_rdata;
		end else if (cmd.advance) begin
			ft_q <= tt_q;
		end
		if (cmd.cap_tt) begin
			tt_q <= t_rdata;
		end
		if (cmd.cap_fl) begin
			fl_q <= l_rdata;
		end
		if (cmd.cap_tl) begin
			tl_q <= l_rdata;
		end
		if (cmd.mul) begin
			prod_s1 <= signed'(dnow) * diff;
			fv_s1   <= fv;
		end
		if (cmd.div_start) begin
			neg_q <= prod_s1[kli_pkg::PRD_W-1];
			rem_q <= abs_prod;
			dsh_q <= kli_pkg::PRD_W'(span) << (kli_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[kli_pkg::QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.chan_done) begin
			res_q <= kli_pkg::chan_put(res_q, chan_q, v[15:0]);
		end
		if (cmd.out_load) begin
			oled_q  <= 3'(led_q);
			olev_q  <= cmd.out_ended ? '0 : res_q;
			oend_q  <= cmd.out_ended;
			olast_q <= (led_q == LW'(LED_COUNT - 1));
		end
	end

	assign sts.done      = done_q;
	assign sts.in_range  = (ft_s <= now_s) && (now_s < tt_s);
	assign sts.to_at_end = (32'(to_q) + 1) >= KEY_COUNT;
	assign sts.tt_end    = (tt_q == kli_pkg::END_MARK);
	assign sts.div_last  = (cnt_q == '0);
	assign sts.chan_last = (chan_q == kli_pkg::CHAN_W'(kli_pkg::NUM_CHAN - 1));
	assign sts.led_last  = (led_q == LW'(LED_COUNT - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_led    = oled_q;
	assign out_levels = olev_q;
	assign out_ended  = oend_q;
	assign out_last   = olast_q;

endmodule

// File: hdl/kli_ctrl.sv
// Controller: sequences loads, the key search and per-fixture interpolation.
module kli_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_op,
	output logic          in_ready,
	input  kli_pkg::sts_t sts,
	output kli_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_FT, ST_TT, ST_CHK, ST_ADV_RD, ST_ADV_CAP, ST_END_CHK,
		ST_LV_F, ST_LV_T, ST_LV_CAP, ST_MUL, ST_DIV_ST, ST_DIV, ST_FIN,
		ST_OUT, ST_END_OUT
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_op == kli_pkg::OP_LOAD) begin
						cmd.load_we = 1'b1;
					end else begin
						cmd.latch_now = 1'b1;
						if (sts.done) begin
							cmd.led_clr = 1'b1;
							state_d     = ST_END_OUT;
						end else begin
							state_d = ST_FT;
						end
					end
				end
			end
			ST_FT: begin
				cmd.cap_ft   = 1'b1;
				cmd.t_sel_to = 1'b1;
				state_d      = ST_TT;
			end
			ST_TT: begin
				cmd.cap_tt = 1'b1;
				state_d    = ST_CHK;
			end
			ST_CHK: begin
				if (sts.in_range) begin
					cmd.led_clr = 1'b1;
					state_d     = ST_LV_F;
				end else if (sts.to_at_end) begin
					cmd.set_done = 1'b1;
					cmd.led_clr  = 1'b1;
					state_d      = ST_END_OUT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_ADV_RD;
				end
			end
			ST_ADV_RD: begin
				cmd.t_sel_to = 1'b1;
				state_d      = ST_ADV_CAP;
			end
			ST_ADV_CAP: begin
				cmd.cap_tt = 1'b1;
				state_d    = ST_END_CHK;
			end
			ST_END_CHK: begin
				if (sts.tt_end) begin
					cmd.set_done = 1'b1;
					cmd.led_clr  = 1'b1;
					state_d      = ST_END_OUT;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_LV_F: begin
				state_d = ST_LV_T;
			end
			ST_LV_T: begin
				cmd.cap_fl   = 1'b1;
				cmd.l_sel_to = 1'b1;
				state_d      = ST_LV_CAP;
			end
			ST_LV_CAP: begin
				cmd.cap_tl   = 1'b1;
				cmd.chan_clr = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV_ST;
			end
			ST_DIV_ST: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.chan_done = 1'b1;
				if (sts.chan_last) begin
					state_d = ST_OUT;
				end else begin
					cmd.chan_inc = 1'b1;
					state_d      = ST_MUL;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.led_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.led_inc = 1'b1;
						state_d     = ST_LV_F;
					end
				end
			end
			ST_END_OUT: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_ended = 1'b1;
					if (sts.led_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.led_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/keyframe_light_interpolator_unit.sv
// Top level of the keyframe lighting cue player.
// A load word (tuser = 0) writes one fixture's RGBW, pan, tilt and the slot's key
// time. A tick word (tuser = 1) carries the playback time; the player walks its
// from/to key pair forward (two table reads to start) until from.time <= now <
// to.time, then gives one output word per fixture, in fixture order, tlast on the
// final one. Each fixture reads its from and to levels, works its 6 channels in
// turn through the 17-step serial divider shared by all channels, and hands the
// word to the output register, waiting while the output side stalls. A key time
// of -1, or running past the last slot, latches an ended state: every later tick
// gives LED_COUNT words with zero levels and tuser set. Reading table slots that
// were never loaded gives meaningless levels. New words are taken only when the
// player is idle; the last output word may still wait in the output register
// then.
module keyframe_light_interpolator_unit #(
	parameter int KEY_COUNT = 256,
	parameter int LED_COUNT = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [7:0] key_index, [32:8] key_time, [35:33] led_index, [43:36] red,
	// [51:44] green, [59:52] blue, [67:60] white, [83:68] pan, [99:84] tilt,
	// [123:100] now_ms, [127:124] zero
	input  logic [127:0] s_tdata,
	// [0] op
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [2:0] out_led, [10:3] out_red, [18:11] out_green, [26:19] out_blue,
	// [34:27] out_white, [50:35] out_pan, [66:51] out_tilt, [71:67] zero
	output logic [71:0]  m_tdata,
	// [0] ended_flag
	output logic         m_tuser,
	output logic         m_tlast
);

	kli_pkg::cmd_t cmd;
	kli_pkg::sts_t sts;

	logic [kli_pkg::LVL_W-1:0] out_levels;
	logic [2:0]                out_led;

	kli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// level word layout matches the output: rgbw bytes low, pan, tilt high
	kli_dp #(.KEY_COUNT(KEY_COUNT), .LED_COUNT(LED_COUNT)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.key_index   (s_tdata[7:0]),
		.key_time    (signed'(s_tdata[32:8])),
		.led_index   (s_tdata[35:33]),
		.load_levels (s_tdata[99:36]),
		.now_ms      (s_tdata[123:100]),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_led     (out_led),
		.out_levels  (out_levels),
		.out_ended   (m_tuser),
		.out_last    (m_tlast)
	);

	assign m_tdata = {5'd0, out_levels, out_led};

	// ended state never clears once latched
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> sts.done)
		else $error("ended state cleared");

	// ended words carry zero levels
	a_ended_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[66:3] == '0))
		else $error("ended word with nonzero levels");

	// controller never overwrites a word still waiting downstream
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output word overwritten");

endmodule
